>>> rtl/core/tcma_pkg.sv
// Package for the two-channel moving average: sizes, derived widths and the result type.
package tcma_pkg;

    localparam int WINDOW      = 512;
    localparam int SAMPLE_BITS = 12;
    localparam int CHANNELS    = 2;

    localparam int SAMPLE_W = 12;
    localparam int AVG_W    = 12;
    localparam int SHIFT    = $clog2(WINDOW);
    localparam int PTR_W    = SHIFT;
    localparam int ADDR_W   = PTR_W + 1;
    localparam int RAM_DEPTH = CHANNELS * WINDOW;
    localparam int SUM_W    = SAMPLE_BITS + SHIFT;

    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic             channel;
        logic [AVG_W-1:0] average;
    } result_t;

endpackage

>>> rtl/core/two_channel_moving_average.sv
// Top level of the two-channel boxcar moving average over per-channel running sums.
//
//   Channel   Direction   Handshake            Payload
//   in        input       in_valid, in_stall   sample
//   out       output      out_valid, out_stall channel, average
//
// One sample is accepted per cycle while in_stall is low; its average is formed from the
// registered read of the history RAM and the running-sum update, then queued as a result.
// Reset clears the pointers, sums and lap flags at once; the history RAM is not cleared,
// as an entry is only read as history once its channel has completed a full lap.
// A three-entry result queue absorbs output stalls, and input is stalled whenever
// that queue and the item in flight together fill it.
module two_channel_moving_average
    import tcma_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                channel,
    output logic [AVG_W-1:0]    average
);

    logic                   ch_reg;
    logic [PTR_W-1:0]       ptr_reg [CHANNELS];
    logic [CHANNELS-1:0]    lapped_reg;
    logic [SUM_W-1:0]       sum_reg [CHANNELS];

    logic                   s1_valid_reg;
    logic                   s1_ch_reg;
    logic                   s1_lapped_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;

    result_t                fifo_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]  cnt_reg;
    logic [FIFO_CNT_W-1:0]  cnt_next;

    logic                   accept;
    logic                   pop;
    logic [FIFO_CNT_W:0]    occupancy;
    logic [SAMPLE_BITS-1:0] x;
    logic [ADDR_W-1:0]      addr;
    logic [SAMPLE_BITS-1:0] rdata;
    logic [SAMPLE_BITS-1:0] oldest;
    logic [SUM_W-1:0]       sum_next;
    result_t                result;

    assign occupancy = {1'b0, cnt_reg} + (FIFO_CNT_W + 1)'(s1_valid_reg);
    assign in_stall  = occupancy >= (FIFO_CNT_W + 1)'(FIFO_DEPTH);
    assign accept    = in_valid && !in_stall;
    assign x         = sample[SAMPLE_BITS-1:0];
    assign addr      = {ch_reg, ptr_reg[ch_reg]};

    tcma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (accept),
        .waddr (addr),
        .wdata (x),
        .raddr (addr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg       <= 1'b0;
            lapped_reg   <= '0;
            s1_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                ptr_reg[i] <= '0;
            end
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                ch_reg          <= !ch_reg;
                ptr_reg[ch_reg] <= ptr_reg[ch_reg] + PTR_W'(1);
                if (ptr_reg[ch_reg] == PTR_W'(WINDOW - 1))
                begin
                    lapped_reg[ch_reg] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ch_reg     <= ch_reg;
            s1_lapped_reg <= lapped_reg[ch_reg];
            s1_sample_reg <= x;
        end
    end

    // The oldest entry only counts once the channel has filled its ring.
    assign oldest   = s1_lapped_reg ? rdata : '0;
    assign sum_next = sum_reg[s1_ch_reg] - SUM_W'(oldest) + SUM_W'(s1_sample_reg);

    always_comb
    begin
        result.channel = s1_ch_reg;
        result.average = AVG_W'(sum_next[SUM_W-1:SHIFT]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else if (s1_valid_reg)
        begin
            sum_reg[s1_ch_reg] <= sum_next;
        end
    end

    assign pop = out_valid && !out_stall;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (s1_valid_reg && !pop)
        begin
            cnt_next = cnt_reg + FIFO_CNT_W'(1);
        end
        else if (!s1_valid_reg && pop)
        begin
            cnt_next = cnt_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (s1_valid_reg)
            begin
                wr_ptr_reg <= (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + FIFO_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            fifo_reg[wr_ptr_reg] <= result;
        end
    end

    assign out_valid = cnt_reg != '0;
    assign channel   = fifo_reg[rd_ptr_reg].channel;
    assign average   = fifo_reg[rd_ptr_reg].average;

endmodule

>>> rtl/core/tcma_ram.sv
// Generic simple dual-port RAM with one write port and a registered, read-first read port.
module tcma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/tcma_checker.sv
// Port-level checker for the two-channel moving average and its bind statement.
module tcma_checker
    import tcma_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic                channel,
    input logic [AVG_W-1:0]    average
);

    logic                  expect_ch_reg;
    logic [FIFO_CNT_W-1:0] pending_reg;
    logic                  in_txn;
    logic                  out_txn;

    assign in_txn  = in_valid && !in_stall;
    assign out_txn = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_ch_reg <= 1'b0;
            pending_reg   <= '0;
        end
        else
        begin
            if (out_txn)
            begin
                expect_ch_reg <= !expect_ch_reg;
            end
            pending_reg <= pending_reg + FIFO_CNT_W'(in_txn) - FIFO_CNT_W'(out_txn);
        end
    end

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(channel) && $stable(average))
        else $error("result changed while stalled");

    // Results alternate between the channels, starting at channel zero.
    a_channel_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> channel == expect_ch_reg)
        else $error("result channel out of order");

    // No result appears without an input transaction still owed one.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != '0)
        else $error("result without a pending input");

    // The block stops taking samples once its result buffering is full.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg >= FIFO_CNT_W'(FIFO_DEPTH) |-> in_stall)
        else $error("input taken with buffering full");

    // Input is never stalled while nothing is owed downstream.
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == '0 |-> !in_stall)
        else $error("input stalled while empty");

endmodule

bind two_channel_moving_average tcma_checker u_tcma_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .channel   (channel),
    .average   (average)
);

>>> sim/tb_top.sv
// Self-checking testbench for the two-channel moving average, with a running-sum predictor.
module tb_top
    import tcma_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 870;
    localparam int IDLE_PERCENT   = 17;
    localparam int QUIET_FROM     = 700;
    localparam int QUIET_TO       = 1000;
    localparam int HOLD_AT        = 150;
    localparam int HOLD_LEN       = 60;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int REPORT_LIMIT   = 10;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic [SAMPLE_W-1:0] sample    = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                channel;
    logic [AVG_W-1:0]    average;

    logic [SAMPLE_BITS-1:0] ring_mem [CHANNELS][WINDOW];
    logic [SUM_W-1:0]       ring_sum [CHANNELS];
    logic [PTR_W-1:0]       ring_ptr [CHANNELS];
    logic                   next_chan;
    int                     laps [CHANNELS];

    logic [SAMPLE_W-1:0] adc_queue [$];
    result_t             expected_avgs [$];

    int  total_items   = 0;
    int  accepted      = 0;
    int  checked       = 0;
    int  errors        = 0;
    int  input_stalls  = 0;
    int  cycle_no      = 0;
    int  idle_cycles   = 0;
    int  hold_left     = 0;
    bit  in_fire       = 1'b0;
    bit  out_fire      = 1'b0;
    logic quiet;

    assign quiet = (cycle_no >= QUIET_FROM) && (cycle_no < QUIET_TO);

    two_channel_moving_average dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .channel   (channel),
        .average   (average)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void predict_average(input logic [SAMPLE_W-1:0] raw);
        logic                   ch;
        logic [SAMPLE_BITS-1:0] x;
        logic [SUM_W-1:0]       sum;
        result_t                r;
        ch  = next_chan;
        x   = raw[SAMPLE_BITS-1:0];
        sum = ring_sum[ch] - SUM_W'(ring_mem[ch][ring_ptr[ch]]) + SUM_W'(x);
        ring_sum[ch] = sum;
        ring_mem[ch][ring_ptr[ch]] = x;
        ring_ptr[ch] = ring_ptr[ch] + PTR_W'(1);
        if (ring_ptr[ch] == '0)
        begin
            laps[ch]++;
        end
        r.channel = ch;
        r.average = AVG_W'(sum >> SHIFT);
        expected_avgs.push_back(r);
        next_chan = ~ch;
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        in_fire  = rst_n && in_valid && !in_stall;
        out_fire = rst_n && out_valid && !out_stall;
        if (rst_n)
        begin
            cycle_no++;
        end
        if (rst_n && in_valid && in_stall)
        begin
            input_stalls++;
        end
        if (in_fire)
        begin
            predict_average(sample);
            accepted++;
        end
        if (out_fire)
        begin
            checked++;
            if (expected_avgs.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                begin
                    $display("Unexpected result transaction: channel %0d average %0d",
                             channel, average);
                end
            end
            else
            begin
                want = expected_avgs.pop_front();
                if (channel !== want.channel || average !== want.average)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                    begin
                        $display("Mismatch %0d: want ch %0d avg %0d, got ch %0d avg %0d",
                                 checked, want.channel, want.average, channel, average);
                    end
                end
            end
        end
        if (!rst_n || in_fire || out_fire)
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired after %0d cycles with no transaction.", idle_cycles);
            $display("FAIL two_channel_moving_average");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fire))
        begin
            if (adc_queue.size() > 0 && (quiet || $urandom_range(99) >= IDLE_PERCENT))
            begin
                in_valid <= 1'b1;
                sample   <= adc_queue.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (cycle_no == HOLD_AT)
        begin
            hold_left = HOLD_LEN;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= rst_n && !quiet && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    initial
    begin
        logic [SAMPLE_W-1:0] v;
        int                  mode;
        int                  run_len;
        int                  random_count;

        for (int c = 0; c < CHANNELS; c++)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                ring_mem[c][i] = '0;
            end
            ring_sum[c] = '0;
            ring_ptr[c] = '0;
            laps[c]     = 0;
        end
        next_chan = 1'b0;

        adc_queue = {12'h000, 12'hfff, 12'hfff, 12'h000, 12'h555, 12'haaa, 12'h800, 12'h001,
                     12'h7ff, 12'hffe, 12'h001, 12'h002, 12'h004, 12'h008, 12'h010, 12'h020,
                     12'h040, 12'h080, 12'h100, 12'h200, 12'h400, 12'h800, 12'hfff, 12'hfff};

        random_count = 0;
        while (random_count < RANDOM_ITEMS)
        begin
            mode    = $urandom_range(9);
            run_len = $urandom_range(48, 1);
            repeat (run_len)
            begin
                case (mode)
                    5: v = '1;
                    6: v = '0;
                    7: v = SAMPLE_W'(1) << $urandom_range(SAMPLE_W - 1);
                    8: v = SAMPLE_W'($urandom_range(15));
                    9: v = '1 - SAMPLE_W'($urandom_range(15));
                    default: v = SAMPLE_W'($urandom_range((1 << SAMPLE_W) - 1));
                endcase
                adc_queue.push_back(v);
                random_count++;
            end
        end
        total_items = adc_queue.size();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (accepted < total_items)
        begin
            @(posedge clk);
        end
        while (expected_avgs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d samples and %0d averages across both channels.",
                 accepted, checked);
        $display("Ring laps: channel 0 %0d, channel 1 %0d; input stalled for %0d cycles.",
                 laps[0], laps[1], input_stalls);
        if (errors == 0 && expected_avgs.size() == 0)
        begin
            $display("PASS two_channel_moving_average");
        end
        else
        begin
            $display("%0d mismatches counted.", errors);
            $display("FAIL two_channel_moving_average");
        end
        $finish;
    end

endmodule
